[design/fcb_name_builder_macros.svh]
// assertion macros used by the name builder back end
`ifndef FCB_NAME_BUILDER_MACROS_SVH
`define FCB_NAME_BUILDER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FNB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FNB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fnb_pkg.sv]
// shared widths and name characters for the 8.3 name builder
package fnb_pkg;

    // width of a name character and of an output name byte
    localparam int BYTE_W = 8;

    // width of the position field on the output channel
    localparam int FCB_POS_W = 4;

    // name characters with a meaning of their own
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ANY     = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LOW_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOW_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] UPPER_MASK = 8'hDF;

endpackage

[design/fnb_if.sv]
// valid/ready channel interfaces for name characters and name bytes
interface fnb_char_if;
    logic                        valid;
    logic                        ready;
    logic [fnb_pkg::BYTE_W-1:0]  char_in;
    logic                        start_req;

    modport source (output valid, output char_in, output start_req, input ready);
    modport sink   (input valid, input char_in, input start_req, output ready);
endinterface

interface fnb_byte_if;
    logic                           valid;
    logic                           ready;
    logic [fnb_pkg::BYTE_W-1:0]     fcb_byte;
    logic [fnb_pkg::FCB_POS_W-1:0]  fcb_position;
    logic                           last;

    modport source (output valid, output fcb_byte, output fcb_position, output last,
                    input ready);
    modport sink   (input valid, input fcb_byte, input fcb_position, input last,
                    output ready);
endinterface

[design/fnb_front.sv]
// front end: parses name characters and issues byte-run commands
module fnb_front #(
    parameter int STEM_LEN = 8,
    parameter int EXT_LEN  = 3,
    parameter int POS_W    = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    fnb_char_if.sink                              char_chan,
    input  logic                                  cmd_full,
    output logic                                  cmd_valid,
    output logic [fnb_pkg::BYTE_W+2*POS_W-1:0]    cmd_data
);

    localparam logic [POS_W-1:0] STEM_P    = POS_W'(STEM_LEN);
    localparam logic [POS_W-1:0] EXT_P     = POS_W'(EXT_LEN);
    localparam logic [POS_W-1:0] STEM_LAST = POS_W'(STEM_LEN - 1);
    localparam logic [POS_W-1:0] NAME_LAST = POS_W'(STEM_LEN + EXT_LEN - 1);

    localparam logic [fnb_pkg::BYTE_W-1:0] CH_NUL    = fnb_pkg::CH_NUL;
    localparam logic [fnb_pkg::BYTE_W-1:0] CH_STAR   = fnb_pkg::CH_STAR;
    localparam logic [fnb_pkg::BYTE_W-1:0] CH_BSLASH = fnb_pkg::CH_BSLASH;
    localparam logic [fnb_pkg::BYTE_W-1:0] CH_DOT    = fnb_pkg::CH_DOT;
    localparam logic [fnb_pkg::BYTE_W-1:0] CH_SPACE  = fnb_pkg::CH_SPACE;
    localparam logic [fnb_pkg::BYTE_W-1:0] CH_ANY    = fnb_pkg::CH_ANY;
    localparam logic [fnb_pkg::BYTE_W-1:0] CH_LOW_A  = fnb_pkg::CH_LOW_A;
    localparam logic [fnb_pkg::BYTE_W-1:0] CH_LOW_Z  = fnb_pkg::CH_LOW_Z;
    localparam logic [fnb_pkg::BYTE_W-1:0] UPPER_MASK = fnb_pkg::UPPER_MASK;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_STEM       = 5'b00010,
        PH_SKIP       = 5'b00100,
        PH_AFTER_STAR = 5'b01000,
        PH_EXT        = 5'b10000
    } phase_t;

    phase_t                       phase_reg, phase_next, eff_phase;
    logic [POS_W-1:0]             fc_reg, fc_next, eff_fc, fc_inc, ext_pos;
    logic                         accept, term, is_star;
    logic [fnb_pkg::BYTE_W-1:0]   ch, ch_up, pad;
    logic [fnb_pkg::BYTE_W-1:0]   c_byte;
    logic [POS_W-1:0]             c_first, c_last;
    logic                         emit;

    // classify the incoming character
    assign ch      = char_chan.char_in;
    assign is_star = (ch == CH_STAR);
    assign term    = (ch == CH_NUL) || is_star || (ch == CH_BSLASH) ||
                     (ch == CH_DOT) || (ch == CH_SPACE);
    assign pad     = is_star ? CH_ANY : CH_SPACE;
    assign ch_up   = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? (ch & UPPER_MASK) : ch;

    assign char_chan.ready = !cmd_full;
    assign accept          = char_chan.valid && !cmd_full;

    // start of a new name overrides the parse state
    assign eff_phase = char_chan.start_req ? PH_STEM : phase_reg;
    assign eff_fc    = char_chan.start_req ? '0 : fc_reg;
    assign fc_inc    = POS_W'(eff_fc + 1'b1);
    assign ext_pos   = POS_W'(STEM_P + eff_fc);

    // parse step: next state and the byte run to issue
    always_comb
    begin
        phase_next = phase_reg;
        fc_next    = fc_reg;
        emit       = 1'b0;
        c_byte     = ch_up;
        c_first    = eff_fc;
        c_last     = eff_fc;
        if (accept)
        begin
            phase_next = eff_phase;
            fc_next    = eff_fc;
            case (eff_phase)
                PH_STEM:
                begin
                    emit = 1'b1;
                    if (term)
                    begin
                        c_byte  = pad;
                        fc_next = '0;
                        if (is_star)
                        begin
                            c_last     = STEM_LAST;
                            phase_next = PH_AFTER_STAR;
                        end
                        else if (ch == CH_DOT)
                        begin
                            c_last     = STEM_LAST;
                            phase_next = PH_EXT;
                        end
                        else
                        begin
                            // stem and extension padded in one run
                            c_last     = NAME_LAST;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (fc_inc >= STEM_P)
                    begin
                        fc_next    = '0;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                    end
                end
                PH_SKIP:
                begin
                    if (ch == CH_DOT)
                    begin
                        phase_next = PH_EXT;
                        fc_next    = '0;
                    end
                    else if (ch == CH_NUL || ch == CH_BSLASH)
                    begin
                        emit       = 1'b1;
                        c_byte     = CH_SPACE;
                        c_first    = STEM_P;
                        c_last     = NAME_LAST;
                        phase_next = PH_IDLE;
                        fc_next    = '0;
                    end
                end
                PH_AFTER_STAR, PH_EXT:
                begin
                    // one dot right after a star is swallowed
                    if (eff_phase == PH_AFTER_STAR && ch == CH_DOT)
                    begin
                        phase_next = PH_EXT;
                        fc_next    = '0;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        c_first = ext_pos;
                        if (term)
                        begin
                            c_byte     = pad;
                            c_last     = NAME_LAST;
                            phase_next = PH_IDLE;
                            fc_next    = '0;
                        end
                        else
                        begin
                            c_last = ext_pos;
                            if (fc_inc >= EXT_P)
                            begin
                                phase_next = PH_IDLE;
                                fc_next    = '0;
                            end
                            else
                            begin
                                phase_next = PH_EXT;
                                fc_next    = fc_inc;
                            end
                        end
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    fc_next    = '0;
                end
            endcase
        end
    end

    assign cmd_valid = emit;
    assign cmd_data  = {c_byte, c_first, c_last};

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
        end
    end

endmodule

[design/fnb_queue.sv]
// short command queue between front and back ends
module fnb_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/fnb_back.sv]
// back end: expands byte-run commands into output beats
`include "fcb_name_builder_macros.svh"

module fnb_back #(
    parameter int STEM_LEN = 8,
    parameter int EXT_LEN  = 3,
    parameter int POS_W    = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_empty,
    input  logic [fnb_pkg::BYTE_W+2*POS_W-1:0]    cmd_head,
    output logic                                  cmd_pop,
    fnb_byte_if.source                            byte_chan
);

    localparam logic [POS_W-1:0] NAME_LAST = POS_W'(STEM_LEN + EXT_LEN - 1);

    logic                         cur_valid_reg, cur_valid_next;
    logic [fnb_pkg::BYTE_W-1:0]   cur_byte_reg, cur_byte_next;
    logic [POS_W-1:0]             cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0]             cur_end_reg, cur_end_next;
    logic                         fire, at_end, load;

    assign fire    = byte_chan.valid && byte_chan.ready;
    assign at_end  = (cur_pos_reg == cur_end_reg);
    assign load    = !cmd_empty && (!cur_valid_reg || (fire && at_end));
    assign cmd_pop = load;

    // current run: step the position or take the next command
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_byte_next  = cur_byte_reg;
        cur_pos_next   = cur_pos_reg;
        cur_end_next   = cur_end_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            {cur_byte_next, cur_pos_next, cur_end_next} = cmd_head;
        end
        else if (fire)
        begin
            if (at_end)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                cur_pos_next = POS_W'(cur_pos_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
        cur_pos_reg  <= cur_pos_next;
        cur_end_reg  <= cur_end_next;
    end

    // output beat straight from the run register
    assign byte_chan.valid        = cur_valid_reg;
    assign byte_chan.fcb_byte     = cur_byte_reg;
    assign byte_chan.fcb_position = fnb_pkg::FCB_POS_W'(cur_pos_reg);
    assign byte_chan.last         = (cur_pos_reg == NAME_LAST);

    // run position never passes its end
    `FNB_ASSERT_IMP(a_pos_in_run, cur_valid_reg, cur_pos_reg <= cur_end_reg, "run overrun")
    // mid-run beat advances the position by one
    `FNB_ASSERT_NXT(a_pos_step, fire && !at_end,
                    cur_valid_reg && cur_pos_reg == POS_W'($past(cur_pos_reg) + 1'b1),
                    "run position did not step")
    // run finished with nothing queued leaves the output empty
    `FNB_ASSERT_NXT(a_drain, fire && at_end && cmd_empty, !cur_valid_reg,
                    "beat invented after run end")

endmodule

[design/fcb_name_builder.sv]
// Builds the eleven-byte 8.3 directory name from a stream of name characters.
// One character is taken per cycle; a character that writes one name byte gives
// one output beat, whose command passes through the command queue and then the
// back end's run register before the beat leaves. A terminator that pads a field
// becomes a single run command, and the back end drives one beat of that run per
// cycle while the output is ready, so a character that pads k bytes gives k
// beats (at most STEM_LEN + EXT_LEN). The front end keeps taking characters while
// the four-entry command queue has room; input stalls only while that queue is
// full, which long pad runs or output back-pressure can cause. Characters that
// write nothing (skipped stem overflow, idle input, the dot after a star) are taken without issuing a run command.
module fcb_name_builder #(
    parameter int STEM_LEN = 8,
    parameter int EXT_LEN  = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    fnb_char_if.sink    char_chan,
    fnb_byte_if.source  byte_chan
);

    localparam int POS_W     = $clog2(STEM_LEN + EXT_LEN + 1);
    localparam int CMD_W     = fnb_pkg::BYTE_W + 2 * POS_W;
    localparam int CMD_DEPTH = 4;

    logic             cmd_valid, cmd_full, cmd_empty, cmd_pop;
    logic [CMD_W-1:0] cmd_data, cmd_head;

    // character parser
    fnb_front #(
        .STEM_LEN (STEM_LEN),
        .EXT_LEN  (EXT_LEN),
        .POS_W    (POS_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_chan (char_chan),
        .cmd_full  (cmd_full),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data)
    );

    // run command queue
    fnb_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_data (cmd_data),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .empty     (cmd_empty),
        .head      (cmd_head)
    );

    // byte run expander
    fnb_back #(
        .STEM_LEN (STEM_LEN),
        .EXT_LEN  (EXT_LEN),
        .POS_W    (POS_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .byte_chan (byte_chan)
    );

endmodule
